@@ rtl/rsqe_pkg.sv @@
// ----------------------------------------------------------------------------
// rsqe_pkg: shared definitions for the rotated sprite quad expander
// Constants, register map, sequencer states and small lookup functions.
// ----------------------------------------------------------------------------
package rsqe_pkg;

  // Billboard numbering
  localparam int MaxBillboards = 65536;
  localparam int CntW          = $clog2(MaxBillboards);
  localparam int IdxW          = 18;

  // Rotation unit
  localparam int CordicSteps = 16;
  localparam int AtanN       = 24;
  localparam int CordicRun   = (CordicSteps < AtanN) ? CordicSteps : AtanN;
  localparam int StepW       = $clog2(AtanN);
  localparam int CsW         = 34;                 // sine, cosine, CORDIC datapath
  localparam int AccW        = 67;                 // scale times offset plus rounding
  localparam int OffW        = AccW - 31;          // offset after the 2^31 divide
  localparam int SumW        = OffW + 1;

  localparam logic signed [CsW-1:0] GainQ30 = CsW'(652032874);
  localparam logic signed [CsW-1:0] OneQ30  = CsW'(1073741824);

  // Register map, word index into the configuration space
  localparam int PaddrW = 5;
  typedef enum logic [2:0] {
    REG_ROT_MODE  = 3'd0,
    REG_SHR_ANGLE = 3'd1,
    REG_SCALE     = 3'd2,
    REG_RED       = 3'd3,
    REG_GREEN     = 3'd4,
    REG_BLUE      = 3'd5
  } reg_idx_t;

  // Angle source
  typedef enum logic [1:0] {
    ROT_NONE   = 2'd0,
    ROT_SHARED = 2'd1,
    ROT_ITEM   = 2'd2,
    ROT_RSVD   = 2'd3
  } rot_mode_t;

  // Result kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_QUAD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_EMIT_V,
    ST_EMIT_I
  } state_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [CsW-1:0] atan_lut(input logic [StepW-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return $signed({2'b00, v});
  endfunction

  // Corner numbers of the two triangles: 0,1,2 then 2,3,0.
  function automatic logic [1:0] tri_corner(input logic [2:0] n);
    logic [1:0] c;
    case (n)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd3;
      3'd5:    c = 2'd0;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/rotated_sprite_quad_expander.sv @@
// ----------------------------------------------------------------------------
// rotated_sprite_quad_expander: billboard center to rotated quad
// Turns each billboard center into four rotated corner vertices followed by
// six triangle index records, using one CORDIC stage and one multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ----------------------------------
//  in_*      input      in_valid/in_ready    center_x, center_y, angle, batch
//  out_*     output     out_valid/out_ready  kind, vertex, tex, color, index
//  APB       config     psel/penable/pready  rotation, angle, scale, color
//
//  An item passes through one accept, the CORDIC micro-rotations and one
//  quadrant restore (both skipped without rotation), then six multiply and
//  sum steps plus one emit per corner, then six index emits. The single
//  18x34 multiplier and the CORDIC shift-add stage set the length of this
//  sequence. in_ready is high only while the sequencer is idle. A stalled
//  output holds the sequencer at its next emit. rst_n is synchronous and
//  active low.
//
module rotated_sprite_quad_expander
  import rsqe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_center_x,
  input  logic signed [31:0]   in_center_y,
  input  logic [15:0]          in_item_angle,
  input  logic                 in_batch_start,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_result_kind,
  output logic signed [31:0]   out_vertex_x,
  output logic signed [31:0]   out_vertex_y,
  output logic                 out_tex_u,
  output logic                 out_tex_v,
  output logic [15:0]          out_red,
  output logic [15:0]          out_green,
  output logic [15:0]          out_blue,
  output logic [IdxW-1:0]      out_element_index,
  output logic                 out_last_of_item,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Configuration registers
  logic [1:0]  rot_mode_r;
  logic [15:0] shr_angle_r;
  logic [31:0] scale_r;
  logic [15:0] red_r, green_r, blue_r;

  // Sequencer and datapath registers
  state_t                  state_r, state_nxt;
  logic [CntW-1:0]         count_r, count_nxt;
  logic [CntW-1:0]         base_r, base_nxt;
  logic signed [31:0]      cx_r, cx_nxt, cy_r, cy_nxt;
  logic [1:0]              quad_r, quad_nxt;
  logic signed [CsW-1:0]   x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [CsW-1:0]   cos_r, cos_nxt, sin_r, sin_nxt;
  logic [StepW-1:0]        step_r, step_nxt;
  logic [1:0]              corner_r, corner_nxt;
  logic                    axis_r, axis_nxt;
  logic [2:0]              tri_r, tri_nxt;
  logic signed [AccW-1:0]  acc_r, acc_nxt;
  logic signed [31:0]      vx_r, vx_nxt, vy_r, vy_nxt;

  // Output word register
  logic                    ovalid_r, ovalid_nxt;
  logic                    okind_r, okind_nxt;
  logic signed [31:0]      ox_r, ox_nxt, oy_r, oy_nxt;
  logic                    ou_r, ou_nxt, ov_r, ov_nxt;
  logic [15:0]             ored_r, ored_nxt, ogreen_r, ogreen_nxt, oblue_r, oblue_nxt;
  logic [IdxW-1:0]         oidx_r, oidx_nxt;
  logic                    olast_r, olast_nxt;

  // Combinational helpers
  logic                    cfg_wr;
  logic [15:0]             sel_angle, angle_bias, fold_angle;
  logic [1:0]              fold_q;
  logic                    use_rot;
  logic signed [CsW-1:0]   x_sh, y_sh, atan_v;
  logic                    neg_sx, neg_sy;
  logic signed [CsW-1:0]   t_val;
  logic [15:0]             scale_half;
  logic signed [51:0]      prod;
  logic signed [OffW-1:0]  offset;
  logic signed [SumW-1:0]  coord_sum;
  logic signed [31:0]      coord_sat;
  logic                    slot_free;
  logic [IdxW-1:0]         base_idx;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_mode_r  <= ROT_NONE;
      shr_angle_r <= '0;
      scale_r     <= 32'd65536;
      red_r       <= 16'hFFFF;
      green_r     <= 16'hFFFF;
      blue_r      <= 16'hFFFF;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_ROT_MODE:  rot_mode_r  <= pwdata[1:0];
        REG_SHR_ANGLE: shr_angle_r <= pwdata[15:0];
        REG_SCALE:     scale_r     <= pwdata;
        REG_RED:       red_r       <= pwdata[15:0];
        REG_GREEN:     green_r     <= pwdata[15:0];
        REG_BLUE:      blue_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_ROT_MODE:  prdata = {30'd0, rot_mode_r};
      REG_SHR_ANGLE: prdata = {16'd0, shr_angle_r};
      REG_SCALE:     prdata = scale_r;
      REG_RED:       prdata = {16'd0, red_r};
      REG_GREEN:     prdata = {16'd0, green_r};
      REG_BLUE:      prdata = {16'd0, blue_r};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------

  // Angle fold into the first octant pair, quadrant kept for the restore.
  always_comb begin
    use_rot    = (rot_mode_r == ROT_SHARED) || (rot_mode_r == ROT_ITEM);
    sel_angle  = (rot_mode_r == ROT_SHARED) ? shr_angle_r : in_item_angle;
    angle_bias = sel_angle + 16'h2000;
    fold_q     = angle_bias[15:14];
    fold_angle = sel_angle - {fold_q, 14'd0};
  end

  // Shared CORDIC shift-add stage.
  assign x_sh   = x_r >>> step_r;
  assign y_sh   = y_r >>> step_r;
  assign atan_v = atan_lut(step_r);

  // Unscaled corner offset: sx*c - sy*s for x, sx*s + sy*c for y.
  always_comb begin
    neg_sx = (corner_r == 2'd0) || (corner_r == 2'd3);
    neg_sy = (corner_r == 2'd0) || (corner_r == 2'd1);
    if (!axis_r) begin
      t_val = (neg_sx ? -cos_r : cos_r) + (neg_sy ? sin_r : -sin_r);
    end else begin
      t_val = (neg_sx ? -sin_r : sin_r) + (neg_sy ? -cos_r : cos_r);
    end
  end

  // Shared multiplier: one 16-bit half of the scale times the offset.
  assign scale_half = (state_r == ST_MUL_HI) ? scale_r[31:16] : scale_r[15:0];
  assign prod       = $signed({2'b00, scale_half}) * t_val;

  // Divide by 2^31, add to the center and saturate to the int32 range.
  always_comb begin
    offset    = acc_r[AccW-1:31];
    coord_sum = (axis_r ? SumW'(cy_r) : SumW'(cx_r)) + SumW'(offset);
    if (coord_sum > SumW'(64'sd2147483647)) begin
      coord_sat = 32'sh7FFFFFFF;
    end else if (coord_sum < -SumW'(64'sd2147483648)) begin
      coord_sat = 32'sh80000000;
    end else begin
      coord_sat = coord_sum[31:0];
    end
  end

  assign slot_free = !ovalid_r || out_ready;
  assign base_idx  = IdxW'({base_r, 2'b00});

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    quad_r   <= quad_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    cos_r    <= cos_nxt;
    sin_r    <= sin_nxt;
    step_r   <= step_nxt;
    corner_r <= corner_nxt;
    axis_r   <= axis_nxt;
    tri_r    <= tri_nxt;
    acc_r    <= acc_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    okind_r  <= okind_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    ou_r     <= ou_nxt;
    ov_r     <= ov_nxt;
    ored_r   <= ored_nxt;
    ogreen_r <= ogreen_nxt;
    oblue_r  <= oblue_nxt;
    oidx_r   <= oidx_nxt;
    olast_r  <= olast_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    base_nxt   = base_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    quad_nxt   = quad_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    cos_nxt    = cos_r;
    sin_nxt    = sin_r;
    step_nxt   = step_r;
    corner_nxt = corner_r;
    axis_nxt   = axis_r;
    tri_nxt    = tri_r;
    acc_nxt    = acc_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    ovalid_nxt = ovalid_r && !out_ready;
    okind_nxt  = okind_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    ou_nxt     = ou_r;
    ov_nxt     = ov_r;
    ored_nxt   = ored_r;
    ogreen_nxt = ogreen_r;
    oblue_nxt  = oblue_r;
    oidx_nxt   = oidx_r;
    olast_nxt  = olast_r;
    in_ready   = 1'b0;

    case (state_r)
      // Take a billboard, number it and prime the rotation unit.
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          base_nxt   = in_batch_start ? '0 : count_r;
          count_nxt  = (base_nxt == CntW'(MaxBillboards - 1)) ? '0 : base_nxt + 1'b1;
          cx_nxt     = in_center_x;
          cy_nxt     = in_center_y;
          quad_nxt   = fold_q;
          x_nxt      = GainQ30;
          y_nxt      = '0;
          z_nxt      = CsW'($signed({fold_angle, 16'd0}));
          step_nxt   = '0;
          corner_nxt = 2'd0;
          axis_nxt   = 1'b0;
          tri_nxt    = 3'd0;
          cos_nxt    = OneQ30;
          sin_nxt    = '0;
          state_nxt  = use_rot ? ST_CORDIC : ST_MUL_LO;
        end
      end

      // One CORDIC micro-rotation per cycle.
      ST_CORDIC: begin
        if (!z_r[CsW-1]) begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          z_nxt = z_r - atan_v;
        end else begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          z_nxt = z_r + atan_v;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(CordicRun - 1)) begin
          state_nxt = ST_QUAD;
        end
      end

      // Restore the quadrant by exact swaps and negations.
      ST_QUAD: begin
        case (quad_r)
          2'd0:    begin cos_nxt = x_r;  sin_nxt = y_r;  end
          2'd1:    begin cos_nxt = -y_r; sin_nxt = x_r;  end
          2'd2:    begin cos_nxt = -x_r; sin_nxt = -y_r; end
          default: begin cos_nxt = y_r;  sin_nxt = -x_r; end
        endcase
        state_nxt = ST_MUL_LO;
      end

      // Low half of the scale product plus the rounding term.
      ST_MUL_LO: begin
        acc_nxt   = AccW'(prod) + (AccW'(1) <<< 30);
        state_nxt = ST_MUL_HI;
      end

      // High half of the scale product, weighted by 2^16.
      ST_MUL_HI: begin
        acc_nxt   = acc_r + (AccW'(prod) <<< 16);
        state_nxt = ST_SUM;
      end

      // Final coordinate of one axis.
      ST_SUM: begin
        if (!axis_r) begin
          vx_nxt    = coord_sat;
          axis_nxt  = 1'b1;
          state_nxt = ST_MUL_LO;
        end else begin
          vy_nxt    = coord_sat;
          axis_nxt  = 1'b0;
          state_nxt = ST_EMIT_V;
        end
      end

      // Hand one vertex word to the output register.
      ST_EMIT_V: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_VERTEX;
          ox_nxt     = vx_r;
          oy_nxt     = vy_r;
          ou_nxt     = corner_r[0] ^ corner_r[1];
          ov_nxt     = !corner_r[1];
          ored_nxt   = red_r;
          ogreen_nxt = green_r;
          oblue_nxt  = blue_r;
          oidx_nxt   = base_idx + IdxW'(corner_r);
          olast_nxt  = 1'b0;
          corner_nxt = corner_r + 1'b1;
          state_nxt  = (corner_r == 2'd3) ? ST_EMIT_I : ST_MUL_LO;
        end
      end

      // Six triangle index words, the last one closes the billboard.
      ST_EMIT_I: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_INDEX;
          ox_nxt     = '0;
          oy_nxt     = '0;
          ou_nxt     = 1'b0;
          ov_nxt     = 1'b0;
          ored_nxt   = '0;
          ogreen_nxt = '0;
          oblue_nxt  = '0;
          oidx_nxt   = base_idx + IdxW'(tri_corner(tri_r));
          olast_nxt  = (tri_r == 3'd5);
          tri_nxt    = tri_r + 1'b1;
          if (tri_r == 3'd5) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output ports
  assign out_valid         = ovalid_r;
  assign out_result_kind   = okind_r;
  assign out_vertex_x      = ox_r;
  assign out_vertex_y      = oy_r;
  assign out_tex_u         = ou_r;
  assign out_tex_v         = ov_r;
  assign out_red           = ored_r;
  assign out_green         = ogreen_r;
  assign out_blue          = oblue_r;
  assign out_element_index = oidx_r;
  assign out_last_of_item  = olast_r;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Rotated sprite quad expander testbench
// Sends billboard centers through the valid/ready input, programs the APB
// registers between phases, and checks every vertex and index word against
// a cycle-free fixed-point predictor kept in step with the configuration.
// ----------------------------------------------------------------------------
module testbench;
  import rsqe_pkg::*;

  localparam int       QUIET_LIMIT = 2000;   // cycles with no handshake at all
  localparam int       SETTLE      = 4;      // idle cycles after the last word
  localparam int       ROT_STEPS   = CordicRun;
  localparam int       BB_WRAP     = MaxBillboards;
  localparam longint   UNIT_Q30    = 64'sd1073741824;
  localparam longint   START_GAIN  = 64'sd652032874;

  typedef struct {
    logic        kind;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        tu;
    logic        tv;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [17:0] idx;
    logic        last;
  } quad_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_center_x = '0;
  logic signed [31:0] in_center_y = '0;
  logic [15:0]        in_item_angle = '0;
  logic               in_batch_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_result_kind;
  logic signed [31:0] out_vertex_x;
  logic signed [31:0] out_vertex_y;
  logic               out_tex_u;
  logic               out_tex_v;
  logic [15:0]        out_red;
  logic [15:0]        out_green;
  logic [15:0]        out_blue;
  logic [IdxW-1:0]    out_element_index;
  logic               out_last_of_item;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PaddrW-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the block's registers and billboard counter.
  rot_mode_t   cfg_mode = ROT_NONE;
  logic [15:0] cfg_shared = 16'd0;
  logic [31:0] cfg_scale = 32'h0001_0000;
  logic [15:0] cfg_red = 16'hFFFF;
  logic [15:0] cfg_green = 16'hFFFF;
  logic [15:0] cfg_blue = 16'hFFFF;
  int unsigned bb_count = 0;

  quad_word_t  pending_words[$];
  quad_word_t  got_word;
  bit          feed_gaps = 1'b0;
  bit          drain_stalls = 1'b0;
  int          errors = 0;
  int          items_sent = 0;
  int          words_checked = 0;
  int          sat_coords = 0;
  int          restarts = 0;
  int          mode_hits[4] = '{0, 0, 0, 0};
  int          quiet_cycles = 0;

  rotated_sprite_quad_expander uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_item_angle     (in_item_angle),
    .in_batch_start    (in_batch_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_vertex_x      (out_vertex_x),
    .out_vertex_y      (out_vertex_y),
    .out_tex_u         (out_tex_u),
    .out_tex_v         (out_tex_v),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_element_index (out_element_index),
    .out_last_of_item  (out_last_of_item),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic longint cordic_atan(int i);
    case (i)
      0:       return 64'h20000000;
      1:       return 64'h12E4051E;
      2:       return 64'h09FB385B;
      3:       return 64'h051111D4;
      4:       return 64'h028B0D43;
      5:       return 64'h0145D7E1;
      6:       return 64'h00A2F61E;
      7:       return 64'h00517C55;
      8:       return 64'h0028BE53;
      9:       return 64'h00145F2F;
      10:      return 64'h000A2F98;
      11:      return 64'h000517CC;
      12:      return 64'h00028BE6;
      13:      return 64'h000145F3;
      14:      return 64'h0000A2FA;
      15:      return 64'h0000517D;
      16:      return 64'h000028BE;
      17:      return 64'h0000145F;
      18:      return 64'h00000A30;
      19:      return 64'h00000518;
      20:      return 64'h0000028C;
      21:      return 64'h00000146;
      22:      return 64'h000000A3;
      23:      return 64'h00000051;
      default: return 64'h0;
    endcase
  endfunction

  // Cosine and sine in Q2.30: fold to within an eighth turn, rotate, unfold.
  function automatic void unit_vector(input logic [15:0] ang, output longint c,
                                      output longint s);
    int unsigned q;
    int unsigned folded;
    longint      x, y, z, nx;
    int          i;
    q = ((32'(ang) + 32'h2000) >> 14) & 32'd3;
    folded = (32'(ang) - q * 32'h4000) & 32'hFFFF;
    z = folded;
    if (z >= 32768) z -= 65536;
    z = z * 65536;
    x = START_GAIN;
    y = 0;
    for (i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - cordic_atan(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + cordic_atan(i);
      end
      x = nx;
    end
    case (q)
      0:       begin c = x;  s = y;  end
      1:       begin c = -y; s = x;  end
      2:       begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
  endfunction

  // Scale times a Q2.30 direction over 2^31, rounded half up.
  function automatic longint half_offset(longint t);
    longint hi, lo;
    hi = longint'({16'b0, cfg_scale[31:16]}) * t;
    lo = longint'({16'b0, cfg_scale[15:0]}) * t + (64'sd1 <<< 30);
    return (hi + (lo >>> 16)) >>> 15;
  endfunction

  function automatic logic [31:0] clamp_coord(longint v);
    if (v > 64'sd2147483647) begin
      sat_coords++;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat_coords++;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Expected ten words for one billboard: four corners, then two triangles.
  function automatic void expand_billboard(logic signed [31:0] cx_in,
                                           logic signed [31:0] cy_in,
                                           logic [15:0] ang, logic batch);
    longint      cx, cy, c, s, tx, ty;
    int          sx, sy, k, corner;
    logic [31:0] base;
    quad_word_t  w;
    cx = cx_in;
    cy = cy_in;
    c = UNIT_Q30;
    s = 0;
    if (batch) begin
      bb_count = 0;
      restarts++;
    end
    base = bb_count * 4;
    case (cfg_mode)
      ROT_SHARED: unit_vector(cfg_shared, c, s);
      ROT_ITEM:   unit_vector(ang, c, s);
      default:    ;
    endcase
    mode_hits[cfg_mode]++;
    for (k = 0; k < 4; k++) begin
      sx = (k == 1 || k == 2) ? 1 : -1;
      sy = (k >= 2) ? 1 : -1;
      tx = sx * c - sy * s;
      ty = sx * s + sy * c;
      w.kind  = KIND_VERTEX;
      w.vx    = clamp_coord(cx + half_offset(tx));
      w.vy    = clamp_coord(cy + half_offset(ty));
      w.tu    = (k == 1 || k == 2);
      w.tv    = (k < 2);
      w.red   = cfg_red;
      w.green = cfg_green;
      w.blue  = cfg_blue;
      w.idx   = 18'(base + k);
      w.last  = 1'b0;
      pending_words.push_back(w);
    end
    for (k = 0; k < 6; k++) begin
      corner = (k == 5) ? 0 : ((k < 3) ? k : k - 1);
      w = '{KIND_INDEX, 32'd0, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0,
            18'(base + corner), (k == 5)};
      pending_words.push_back(w);
    end
    if (bb_count + 1 >= BB_WRAP) bb_count = 0;
    else bb_count++;
  endfunction

  // Mostly short gaps with an occasional long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF - $urandom_range(0, 32'h3FFFF);
      1:       return 32'h8000_0000 + $urandom_range(0, 32'h3FFFF);
      2:       return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  // Send one billboard word and predict its results once it is taken.
  task automatic send_billboard(logic [31:0] cx, logic [31:0] cy,
                                logic [15:0] ang, logic batch);
    int gap;
    in_valid       <= 1'b1;
    in_center_x    <= cx;
    in_center_y    <= cy;
    in_item_angle  <= ang;
    in_batch_start <= batch;
    do @(posedge clk); while (!in_ready);
    expand_billboard(cx, cy, ang, batch);
    items_sent++;
    gap = (feed_gaps && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off new words until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write while the block is idle; the shadow follows at the access edge.
  task automatic set_reg(reg_idx_t idx, logic [31:0] val);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROT_MODE:  cfg_mode = rot_mode_t'(val[1:0]);
      REG_SHR_ANGLE: cfg_shared = val[15:0];
      REG_SCALE:     cfg_scale = val;
      REG_RED:       cfg_red = val[15:0];
      REG_GREEN:     cfg_green = val[15:0];
      REG_BLUE:      cfg_blue = val[15:0];
      default:       ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_colors(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    set_reg(REG_RED, 32'(r));
    set_reg(REG_GREEN, 32'(g));
    set_reg(REG_BLUE, 32'(b));
  endtask

  // Reset values: unrotated unit quads in full white.
  task automatic test_reset_defaults();
    send_billboard(32'h0, 32'h0, 16'h1234, 1'b1);
    send_billboard(32'h0001_0000, 32'hFFFF_0000, 16'hFFFF, 1'b0);
  endtask

  // No rotation with extreme centers and scales, so coordinates saturate.
  task automatic test_unrotated_extremes();
    set_reg(REG_ROT_MODE, 32'(ROT_NONE));
    set_reg(REG_SCALE, 32'hFFFF_FFFF);
    set_colors(16'h0000, 16'h0000, 16'h0000);
    send_billboard(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h4000, 1'b0);
    send_billboard(32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b0);
    send_billboard(32'h0, 32'h0, 16'h8000, 1'b0);
    set_reg(REG_SCALE, 32'h0);
    send_billboard(32'h8000_0000, 32'h7FFF_FFFF, 16'hC000, 1'b0);
  endtask

  // Per-item angles across the quadrant folds and the wrap of a full turn.
  task automatic test_angle_sweep();
    logic [15:0] angles[10] = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000, 16'h6000,
                                16'h8000, 16'hA000, 16'hC000, 16'hE000, 16'hFFFF};
    int          i;
    set_reg(REG_ROT_MODE, 32'(ROT_ITEM));
    set_reg(REG_SCALE, 32'h0010_0000);
    set_colors(16'h1234, 16'h5678, 16'h9ABC);
    for (i = 0; i < 10; i++)
      send_billboard(32'h0, 32'h0, angles[i], 1'b0);
  endtask

  // Shared angle ignores the word's own angle; the reserved mode rotates not.
  task automatic test_shared_and_reserved();
    set_reg(REG_ROT_MODE, 32'(ROT_SHARED));
    set_reg(REG_SHR_ANGLE, 32'hFFFF);
    send_billboard(32'h0100_0000, 32'hFF00_0000, 16'h4000, 1'b0);
    set_reg(REG_SHR_ANGLE, 32'h0);
    send_billboard(32'h0100_0000, 32'hFF00_0000, 16'hBEEF, 1'b0);
    set_reg(REG_ROT_MODE, 32'(ROT_RSVD));
    set_colors(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_billboard(32'h7FFF_0000, 32'h8000_FFFF, 16'h2000, 1'b0);
  endtask

  // Batch start restarts numbering in the middle of a run.
  task automatic test_batch_restart();
    send_billboard(32'h0000_8000, 32'h0000_8000, 16'h0, 1'b0);
    send_billboard(32'h0000_8000, 32'h0000_8000, 16'h0, 1'b1);
    send_billboard(32'h0000_8000, 32'h0000_8000, 16'h0, 1'b0);
  endtask

  // Random billboard phases: modes 0-3 in turn then random, others random.
  task automatic test_random_traffic();
    int phase, n;
    for (phase = 0; phase < 6; phase++) begin
      set_reg(REG_ROT_MODE, (phase < 4) ? phase : $urandom_range(0, 3));
      set_reg(REG_SHR_ANGLE, $urandom_range(0, 65535));
      set_reg(REG_SCALE, rand_scale());
      set_colors(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
      feed_gaps    = (phase != 2);
      drain_stalls = (phase != 2);
      for (n = 0; n < 42; n++) begin
        if (phase == 3 && n == 21) drain_results();
        send_billboard(rand_coord(), rand_coord(), 16'($urandom_range(0, 65535)),
                       $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Result side: ready toggles in runs and gaps while stalls are enabled.
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (!drain_stalls) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  task automatic check_field(string name, longint unsigned want,
                             longint unsigned got);
    if (want != got) begin
      $display("%0t: word %0d field %s expected %0h actual %0h",
               $time, words_checked, name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual index %0h",
                 $time, out_element_index);
        errors++;
      end else begin
        got_word = pending_words.pop_front();
        check_field("result_kind", got_word.kind, out_result_kind);
        check_field("vertex_x", got_word.vx, $unsigned(out_vertex_x));
        check_field("vertex_y", got_word.vy, $unsigned(out_vertex_y));
        check_field("tex_u", got_word.tu, out_tex_u);
        check_field("tex_v", got_word.tv, out_tex_v);
        check_field("red", got_word.red, out_red);
        check_field("green", got_word.green, out_green);
        check_field("blue", got_word.blue, out_blue);
        check_field("element_index", got_word.idx, out_element_index);
        check_field("last_of_item", got_word.last, out_last_of_item);
      end
      words_checked++;
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_unrotated_extremes();
    test_angle_sweep();
    test_shared_and_reserved();
    test_batch_restart();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk);
    $display("Checked %0d words from %0d billboards; modes none/shared/item/reserved %0d/%0d/%0d/%0d.",
             words_checked, items_sent, mode_hits[0], mode_hits[1], mode_hits[2],
             mode_hits[3]);
    $display("Scale and color extremes included, %0d saturated coordinates, %0d batch restarts.",
             sat_coords, restarts);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
